[hdl/rzc_pkg.sv]
// Shared types, constants and helpers for the rolling z-score CUSUM detector.
// Used by rzc_divider, rzc_sqrt and rolling_zscore_cusum_detector.
// No dependencies.
package rzc_pkg;

   localparam int WINDOW_DEPTH = 256;
   localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = ADDR_W + 1;
   localparam int MIN_HISTORY  = 20;

   localparam logic [1:0] CSR_DRIFT         = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD     = 2'd1;
   localparam logic [1:0] CSR_WINDOW_LENGTH = 2'd2;

   localparam logic [31:0] DRIFT_RESET     = 32'd32768;
   localparam logic [31:0] THRESHOLD_RESET = 32'd327680;
   localparam logic [8:0]  WINLEN_RESET    = 9'd100;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_TRADE = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [31:0] price;
   } req_word_type;

   typedef struct packed {
      logic [31:0] positive_statistic;
      logic [31:0] negative_statistic;
      logic        change_flag;
      logic        statistics_valid;
   } rsp_word_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   // saturate a sign and magnitude to signed 32 bits
   function automatic logic [31:0] sat_signed(input logic neg, input logic [63:0] mag);
      logic [31:0] res;
      if (!neg) begin
         if (mag > 64'h0000_0000_7FFF_FFFF) res = 32'h7FFF_FFFF;
         else res = mag[31:0];
      end else begin
         if (mag > 64'h0000_0000_8000_0000) res = 32'h8000_0000;
         else res = 32'd0 - mag[31:0];
      end
      return res;
   endfunction

endpackage

[hdl/rzc_divider.sv]
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on rzc_pkg.
module rzc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rzc_pkg::div_req_type div_req,
   output rzc_pkg::div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff[31:0], quo_ff[63]};
      if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = 33'd0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[hdl/rzc_sqrt.sv]
// Bitwise floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on rzc_pkg.
module rzc_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  rzc_pkg::sqrt_req_type sqrt_req,
   output rzc_pkg::sqrt_rsp_type sqrt_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      trial   = root_ff + bit_ff;
      if (busy_ff) begin
         if (val_ff >= trial) begin
            val_in  = val_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (sqrt_req.start) begin
         busy_in = 1'b1;
         val_in  = sqrt_req.radicand;
         root_in = 64'd0;
         bit_in  = 64'h4000_0000_0000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff[31:0];

endmodule

[hdl/rolling_zscore_cusum_detector.sv]
// Two-sided CUSUM change detector over z-scored price returns.
// Depends on rzc_pkg, rzc_divider and rzc_sqrt.
//
// Usage: a req word (opcode, price) is taken when req_valid is high and
// req_stall is low. A trade, or a tick with no reference price, goes straight
// to ST_OUT, which loads its rsp word. A tick with reference forms its return
// with one pass of the shared divider; with fewer than 20 returns in the
// window its word then goes through ST_PUSH and ST_OUT. With at least 20
// returns it then sums the window, divides for the mean, sums the squared
// deviations through the multiplier, divides for the variance, takes the
// square root, divides for z and updates the sums.
// req_stall stays high from acceptance until the rsp word is loaded; one
// finished word may wait in the output register while the next is taken.
// When rsp_stall holds off a word and another finishes, the block waits.
// csr_we writes drift, threshold or window_length; write only while idle.
// reset is synchronous: registers return to their reset values, sums, window
// count and reference price clear, and the window memory needs no clearing.
module rolling_zscore_cusum_detector (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rzc_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rzc_pkg::rsp_word_type rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_RDIV  = 11'b000_0000_0010,
      ST_MSUM  = 11'b000_0000_0100,
      ST_MDIV  = 11'b000_0000_1000,
      ST_SQSUM = 11'b000_0001_0000,
      ST_VDIV  = 11'b000_0010_0000,
      ST_SQRT  = 11'b000_0100_0000,
      ST_ZDIV  = 11'b000_1000_0000,
      ST_UPD   = 11'b001_0000_0000,
      ST_PUSH  = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

   localparam int AW = rzc_pkg::ADDR_W;
   localparam int CW = rzc_pkg::CNT_W;

   state_type state_ff, state_in;

   logic [31:0] drift_ff, threshold_ff;
   logic [8:0]  winlen_ff;

   logic [31:0] refp_ff, refp_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] up_ff, up_in, dn_ff, dn_in;
   logic        det_ff, det_in;
   logic [31:0] lat_up_ff, lat_up_in, lat_dn_ff, lat_dn_in;

   logic [31:0] price_ff, price_in;
   logic        neg_ff, neg_in;
   logic [31:0] ret_ff, ret_in;
   logic [40:0] sum_ff, sum_in;
   logic [31:0] mean_ff, mean_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] prod_ff;
   logic [31:0] sigma_ff, sigma_in;
   logic [31:0] z_ff, z_in;
   logic [CW-1:0] k_ff, k_in;
   logic        p1_ff, p1_in, p2_ff, p2_in;
   logic        started_ff, started_in;

   logic [31:0] mem [rzc_pkg::WINDOW_DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic        wr_en;
   logic [AW-1:0] wr_addr;

   rzc_pkg::div_req_type  div_req;
   rzc_pkg::div_rsp_type  div_rsp;
   rzc_pkg::sqrt_req_type sqrt_req;
   rzc_pkg::sqrt_rsp_type sqrt_rsp;

   logic        rsp_valid_ff, rsp_valid_in;
   rzc_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic [32:0] diff;
   logic [31:0] diff_mag;
   logic [32:0] dev;
   logic [31:0] dev_mag;
   logic [32:0] dz;
   logic [31:0] dz_mag;
   logic [39:0] sum_mag;
   logic [64:0] sq_add;
   logic [34:0] p_sum, q_sum;
   logic [31:0] p_clamp, q_clamp;
   logic [8:0]  eff_len;
   logic [CW:0] cnt_p1;
   logic        stats_ok;
   logic        accept;

   rzc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rzc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      diff     = {1'b0, price_ff} - {1'b0, refp_ff};
      diff_mag = diff[32] ? (32'd0 - diff[31:0]) : diff[31:0];
      dev      = {rd_data_ff[31], rd_data_ff} - {mean_ff[31], mean_ff};
      dev_mag  = dev[32] ? (32'd0 - dev[31:0]) : dev[31:0];
      dz       = {ret_ff[31], ret_ff} - {mean_ff[31], mean_ff};
      dz_mag   = dz[32] ? (32'd0 - dz[31:0]) : dz[31:0];
      sum_mag  = sum_ff[40] ? (40'd0 - sum_ff[39:0]) : sum_ff[39:0];
      sq_add   = {1'b0, sq_ff} + {1'b0, prod_ff};
      if (winlen_ff == 9'd0) eff_len = 9'd1;
      else if ({1'b0, winlen_ff} > 10'(rzc_pkg::WINDOW_DEPTH))
         eff_len = 9'(rzc_pkg::WINDOW_DEPTH);
      else eff_len = winlen_ff;
      cnt_p1   = {1'b0, count_ff} + 1'b1;
      stats_ok = (count_ff >= CW'(rzc_pkg::MIN_HISTORY));
      p_sum = {3'b000, up_ff} + {{3{z_ff[31]}}, z_ff} - {3'b000, drift_ff};
      q_sum = {3'b000, dn_ff} - {{3{z_ff[31]}}, z_ff} - {3'b000, drift_ff};
      if (p_sum[34]) p_clamp = 32'd0;
      else if (p_sum[33:32] != 2'b00) p_clamp = 32'hFFFF_FFFF;
      else p_clamp = p_sum[31:0];
      if (q_sum[34]) q_clamp = 32'd0;
      else if (q_sum[33:32] != 2'b00) q_clamp = 32'hFFFF_FFFF;
      else q_clamp = q_sum[31:0];
   end

   always_comb begin
      state_in     = state_ff;
      refp_in      = refp_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      up_in        = up_ff;
      dn_in        = dn_ff;
      det_in       = det_ff;
      lat_up_in    = lat_up_ff;
      lat_dn_in    = lat_dn_ff;
      price_in     = price_ff;
      neg_in       = neg_ff;
      ret_in       = ret_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      sq_in        = sq_ff;
      sigma_in     = sigma_ff;
      z_in         = z_ff;
      k_in         = k_ff;
      p1_in        = 1'b0;
      p2_in        = 1'b0;
      started_in   = started_ff;
      rd_addr      = head_ff + k_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = head_ff + count_ff[AW-1:0];
      div_req      = '0;
      sqrt_req     = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               price_in = req_data.price;
               if (req_data.opcode == rzc_pkg::OP_TICK && refp_ff != 32'd0)
                  state_in = ST_RDIV;
               else
                  state_in = ST_OUT;
            end
         end
         ST_RDIV: begin
            div_req.dividend = {8'd0, diff_mag, 24'd0};
            div_req.divisor  = refp_ff;
            if (!started_ff) begin
               div_req.start = 1'b1;
               started_in    = 1'b1;
               neg_in        = diff[32];
            end else if (div_rsp.done) begin
               started_in = 1'b0;
               ret_in     = rzc_pkg::sat_signed(neg_ff, div_rsp.quotient);
               k_in       = '0;
               sum_in     = '0;
               state_in   = stats_ok ? ST_MSUM : ST_PUSH;
            end
         end
         ST_MSUM: begin
            if (k_ff < count_ff) begin
               k_in  = k_ff + 1'b1;
               p1_in = 1'b1;
            end
            if (p1_ff) sum_in = sum_ff + {{9{rd_data_ff[31]}}, rd_data_ff};
            if (k_ff == count_ff && !p1_ff) state_in = ST_MDIV;
         end
         ST_MDIV: begin
            div_req.dividend = {24'd0, sum_mag};
            div_req.divisor  = {{(32-CW){1'b0}}, count_ff};
            if (!started_ff) begin
               div_req.start = 1'b1;
               started_in    = 1'b1;
            end else if (div_rsp.done) begin
               started_in = 1'b0;
               mean_in    = sum_ff[40] ? (32'd0 - div_rsp.quotient[31:0])
                                       : div_rsp.quotient[31:0];
               k_in       = '0;
               sq_in      = '0;
               state_in   = ST_SQSUM;
            end
         end
         ST_SQSUM: begin
            if (k_ff < count_ff) begin
               k_in  = k_ff + 1'b1;
               p1_in = 1'b1;
            end
            p2_in = p1_ff;
            if (p2_ff) sq_in = sq_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_add[63:0];
            if (k_ff == count_ff && !p1_ff && !p2_ff) state_in = ST_VDIV;
         end
         ST_VDIV: begin
            div_req.dividend = sq_ff;
            div_req.divisor  = {{(32-CW){1'b0}}, count_ff - 1'b1};
            if (!started_ff) begin
               div_req.start = 1'b1;
               started_in    = 1'b1;
            end else if (div_rsp.done) begin
               started_in = 1'b0;
               sq_in      = div_rsp.quotient;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sqrt_req.radicand = sq_ff;
            if (!started_ff) begin
               sqrt_req.start = 1'b1;
               started_in     = 1'b1;
            end else if (sqrt_rsp.done) begin
               started_in = 1'b0;
               sigma_in   = (sqrt_rsp.root == 32'd0) ? 32'd1 : sqrt_rsp.root;
               state_in   = ST_ZDIV;
            end
         end
         ST_ZDIV: begin
            div_req.dividend = {16'd0, dz_mag, 16'd0};
            div_req.divisor  = sigma_ff;
            if (!started_ff) begin
               div_req.start = 1'b1;
               started_in    = 1'b1;
               neg_in        = dz[32];
            end else if (div_rsp.done) begin
               started_in = 1'b0;
               z_in       = rzc_pkg::sat_signed(neg_ff, div_rsp.quotient);
               state_in   = ST_UPD;
            end
         end
         ST_UPD: begin
            det_in = (p_clamp > threshold_ff) || (q_clamp > threshold_ff);
            if ((p_clamp > threshold_ff) || (q_clamp > threshold_ff)) begin
               lat_up_in = p_clamp;
               lat_dn_in = q_clamp;
               up_in     = 32'd0;
               dn_in     = 32'd0;
            end else begin
               up_in = p_clamp;
               dn_in = q_clamp;
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            wr_en = 1'b1;
            if (cnt_p1 > {1'b0, eff_len}) head_in = head_ff + 1'b1;
            else count_in = cnt_p1[CW-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               refp_in      = price_ff;
               rsp_valid_in = 1'b1;
               if (stats_ok) begin
                  rsp_data_in.positive_statistic = det_ff ? lat_up_ff : up_ff;
                  rsp_data_in.negative_statistic = det_ff ? lat_dn_ff : dn_ff;
                  rsp_data_in.change_flag        = det_ff;
                  rsp_data_in.statistics_valid   = 1'b1;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= ret_ff;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drift_ff     <= rzc_pkg::DRIFT_RESET;
         threshold_ff <= rzc_pkg::THRESHOLD_RESET;
         winlen_ff    <= rzc_pkg::WINLEN_RESET;
         refp_ff      <= 32'd0;
         head_ff      <= '0;
         count_ff     <= '0;
         up_ff        <= 32'd0;
         dn_ff        <= 32'd0;
         det_ff       <= 1'b0;
         lat_up_ff    <= 32'd0;
         lat_dn_ff    <= 32'd0;
         started_ff   <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         refp_ff      <= refp_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         up_ff        <= up_in;
         dn_ff        <= dn_in;
         det_ff       <= det_in;
         lat_up_ff    <= lat_up_in;
         lat_dn_ff    <= lat_dn_in;
         started_ff   <= started_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               rzc_pkg::CSR_DRIFT:         drift_ff     <= csr_wdata;
               rzc_pkg::CSR_THRESHOLD:     threshold_ff <= csr_wdata;
               rzc_pkg::CSR_WINDOW_LENGTH: winlen_ff    <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
      price_ff    <= price_in;
      neg_ff      <= neg_in;
      ret_ff      <= ret_in;
      sum_ff      <= sum_in;
      mean_ff     <= mean_in;
      sq_ff       <= sq_in;
      prod_ff     <= dev_mag * dev_mag;
      sigma_ff    <= sigma_in;
      z_ff        <= z_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
